/* src/unique_id_allocator_window_scan_assert.svh */
// Assertion macros for the identifier allocator checker.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef UNIQUE_ID_ALLOCATOR_WINDOW_SCAN_ASSERT_SVH
`define UNIQUE_ID_ALLOCATOR_WINDOW_SCAN_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define UIDA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define UIDA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/uida_pkg.sv */
// Shared constants and codes for the identifier allocator.
// No dependencies; used by the top level, the table RAM and the checker.
package uida_pkg;

	localparam int unsigned EntriesDef = 32;
	localparam int unsigned IdLimitDef = 64;

	localparam int unsigned IdFieldW = 6;
	localparam int unsigned StatusW  = 2;

	typedef enum logic [StatusW-1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_NOT_LIVE = 2'd2
	} status_t;

	typedef enum logic {
		OP_ALLOC   = 1'b0,
		OP_RELEASE = 1'b1
	} opcode_t;

endpackage

/* src/uida_table.sv */
// Live table RAM: one write port, one read port, registered read data.
// Depends on uida_pkg for its default sizes.
module uida_table
	import uida_pkg::*;
#(
	parameter int unsigned DEPTH = EntriesDef,
	parameter int unsigned WIDTH = $clog2(IdLimitDef + 1) + 1
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* src/unique_id_allocator_window_scan.sv */
// Identifier allocator with a last-issued / safe-bound window. Each item is an
// allocate or a release request and yields exactly one result item. After
// reset the block clears every slot of its live table and holds in_stall
// high meanwhile. The live table is a RAM with one read port and registered
// read data, walked one slot per cycle except where a restart skips a read;
// that walk sets the latency. An allocate whose candidate lies below the safe
// bound stops at the lowest free slot. An allocate that needs a window scan
// walks the whole table. Each collision that pushes the candidate up to the
// bound abandons the pass and starts another from slot zero, so a rare
// allocate may take several passes. A release walks the table until the
// identifier is found or the last slot is read. A full table is answered
// without a walk. One item is in work at a time; the result sits in an
// output register, so the next item is taken while an earlier result still
// waits.
//
// Depends on uida_pkg and uida_table.
module unique_id_allocator_window_scan
	import uida_pkg::*;
#(
	parameter int unsigned ENTRIES  = EntriesDef,
	parameter int unsigned ID_LIMIT = IdLimitDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                opcode,
	input  logic [IdFieldW-1:0] release_id,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [IdFieldW-1:0] issued_id,
	output logic [StatusW-1:0]  status
);

	// Widths: slot address, identifier (able to hold ID_LIMIT itself), live
	// count (able to hold ENTRIES) and the pass counter of the window scan.
	localparam int unsigned AW  = $clog2(ENTRIES);
	localparam int unsigned IdW = $clog2(ID_LIMIT + 1);
	localparam int unsigned CW  = $clog2(ENTRIES + 1);
	localparam int unsigned PW  = $clog2(ID_LIMIT + 3);
	localparam int unsigned MW  = IdW + 1;

	localparam logic [AW-1:0]  LastSlot  = AW'(ENTRIES - 1);
	localparam logic [IdW-1:0] IdLimit   = IdW'(ID_LIMIT);
	localparam logic [IdW-1:0] FirstId   = IdW'(1);
	localparam logic [PW-1:0]  PassLimit = PW'(ID_LIMIT + 1);

	typedef enum logic [3:0] {
		S_CLEAR = 4'b0001,
		S_IDLE  = 4'b0010,
		S_SCAN  = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	state_t state_q;

	// Walk control: the read address and the stage that marks the returning
	// read data as valid.
	logic [AW-1:0] rd_addr_q;
	logic          issue_q;
	logic          rd_vld_s1;
	logic [AW-1:0] rd_idx_s1;

	// The request in work.
	logic           op_q;
	logic [IdW-1:0] rel_q;
	logic           scan_q;
	logic [IdW-1:0] cand_q;
	logic [IdW-1:0] bound_q;
	logic [PW-1:0]  passes_q;
	logic           free_found_q;
	logic [AW-1:0]  free_idx_q;

	// Architectural state kept in flops.
	logic [IdW-1:0] last_q;
	logic [IdW-1:0] safe_q;
	logic [CW-1:0]  count_q;

	// Result waiting for the output register, and the output register.
	logic [IdFieldW-1:0] res_id_q;
	status_t             res_st_q;
	logic                out_valid_q;
	logic [IdFieldW-1:0] out_id_q;
	status_t             out_st_q;

	// Table RAM ports.
	logic           mem_we;
	logic [AW-1:0]  mem_waddr;
	logic [MW-1:0]  mem_wdata;
	logic           mem_re;
	logic [MW-1:0]  mem_rdata;

	uida_table #(
		.DEPTH(ENTRIES),
		.WIDTH(MW)
	) u_table (
		.clk    (clk),
		.wr_en  (mem_we),
		.wr_addr(mem_waddr),
		.wr_data(mem_wdata),
		.rd_en  (mem_re),
		.rd_addr(rd_addr_q),
		.rd_data(mem_rdata)
	);

	logic           in_acc;
	logic           e_v;
	logic [IdW-1:0] e_id;
	logic           last_slot;
	logic [IdW-1:0] cand_inc;
	logic           collide;
	logic           restart;
	logic           narrow;
	logic [IdW-1:0] cand_nx;
	logic [IdW-1:0] bound_nx;
	logic           free_now;
	logic [AW-1:0]  free_slot;
	logic           rel_hit;
	logic           rel_miss;
	logic           alloc_end;
	logic           scan_abort;
	logic           finish;
	logic           table_full;
	logic [IdW:0]   cand0;
	logic           out_load;

	assign in_acc = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);

	assign e_v       = mem_rdata[IdW];
	assign e_id      = mem_rdata[IdW-1:0];
	assign last_slot = (rd_idx_s1 == LastSlot);
	assign cand_inc  = cand_q + FirstId;

	// One slot of the window scan. A live identifier equal to the candidate
	// bumps it; when the bumped value reaches the bound the pass is abandoned
	// and the scan starts over from slot zero with the bound reopened. A live
	// identifier between the candidate and the bound narrows the bound.
	assign collide = scan_q && e_v && (e_id == cand_q);
	assign restart = collide && (cand_inc >= bound_q);
	assign narrow  = scan_q && e_v && !collide && (e_id > cand_q) && (bound_q > e_id);

	always_comb begin
		cand_nx  = cand_q;
		bound_nx = bound_q;
		if (collide) begin
			cand_nx = cand_inc;
			if (restart) begin
				cand_nx  = (cand_inc >= IdLimit) ? FirstId : cand_inc;
				bound_nx = IdLimit;
			end
		end else if (narrow) begin
			bound_nx = e_id;
		end
	end

	// The lowest free slot seen so far in this request, including this one.
	assign free_now  = free_found_q || !e_v;
	assign free_slot = free_found_q ? free_idx_q : rd_idx_s1;

	assign rel_hit  = (op_q == OP_RELEASE) && e_v && (e_id == rel_q);
	assign rel_miss = (op_q == OP_RELEASE) && !rel_hit && last_slot;

	// Without a scan the candidate is already known free, so the walk only
	// looks for a slot. With a scan the whole table must be seen.
	always_comb begin
		alloc_end = 1'b0;
		if (op_q == OP_ALLOC) begin
			if (scan_q) begin
				alloc_end = last_slot && !restart;
			end else begin
				alloc_end = !e_v || last_slot;
			end
		end
	end

	assign scan_abort = (op_q == OP_ALLOC) && restart && (passes_q > PassLimit);
	assign finish = (state_q == S_SCAN) && rd_vld_s1 &&
		(rel_hit || rel_miss || alloc_end || scan_abort);

	assign table_full = (32'(count_q) >= 32'(ENTRIES)) ||
		(32'(count_q) >= 32'(ID_LIMIT - 1));
	assign cand0 = {1'b0, last_q} + {{IdW{1'b0}}, 1'b1};

	assign mem_re = issue_q && ((state_q == S_SCAN) && !finish && !(rd_vld_s1 && restart));

	// Write port: the clearing pass after reset, the slot freed by a release
	// or the slot claimed by an allocate.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = rd_idx_s1;
		mem_wdata = '0;
		case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = rd_addr_q;
			end
			S_SCAN: begin
				if (rd_vld_s1 && rel_hit) begin
					mem_we = 1'b1;
				end else if (rd_vld_s1 && alloc_end && free_now) begin
					mem_we    = 1'b1;
					mem_waddr = free_slot;
					mem_wdata = {1'b1, cand_nx};
				end
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			rd_addr_q    <= '0;
			issue_q      <= 1'b0;
			rd_vld_s1    <= 1'b0;
			rd_idx_s1    <= '0;
			op_q         <= OP_ALLOC;
			rel_q        <= '0;
			scan_q       <= 1'b0;
			cand_q       <= '0;
			bound_q      <= '0;
			passes_q     <= '0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
			last_q       <= IdLimit;
			safe_q       <= IdLimit;
			count_q      <= '0;
			res_id_q     <= '0;
			res_st_q     <= ST_OK;
			out_valid_q  <= 1'b0;
			out_id_q     <= '0;
			out_st_q     <= ST_OK;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_CLEAR: begin
					if (rd_addr_q == LastSlot) begin
						rd_addr_q <= '0;
						state_q   <= S_IDLE;
					end else begin
						rd_addr_q <= rd_addr_q + 1'b1;
					end
				end

				S_IDLE: begin
					if (in_acc) begin
						op_q         <= opcode;
						rel_q        <= IdW'(release_id);
						rd_addr_q    <= '0;
						rd_vld_s1    <= 1'b0;
						free_found_q <= 1'b0;
						passes_q     <= PW'(1);
						res_id_q     <= '0;
						if (opcode == OP_RELEASE) begin
							scan_q  <= 1'b0;
							issue_q <= 1'b1;
							state_q <= S_SCAN;
						end else if (table_full) begin
							res_st_q <= ST_FULL;
							state_q  <= S_DONE;
						end else begin
							issue_q <= 1'b1;
							state_q <= S_SCAN;
							if (cand0 >= {1'b0, IdLimit}) begin
								cand_q  <= FirstId;
								scan_q  <= 1'b1;
								bound_q <= IdLimit;
							end else if (cand0[IdW-1:0] >= safe_q) begin
								cand_q  <= cand0[IdW-1:0];
								scan_q  <= 1'b1;
								bound_q <= IdLimit;
							end else begin
								cand_q  <= cand0[IdW-1:0];
								scan_q  <= 1'b0;
								bound_q <= safe_q;
							end
						end
					end
				end

				S_SCAN: begin
					// Issue side: one read per cycle down the table. The end
					// of the request stops the walk; a restart begins another
					// pass from slot zero, and no read is issued in that cycle.
					rd_vld_s1 <= mem_re;
					rd_idx_s1 <= rd_addr_q;
					if (rd_vld_s1 && (finish || restart)) begin
						rd_addr_q <= '0;
						issue_q   <= !finish;
					end else if (issue_q) begin
						rd_addr_q <= rd_addr_q + 1'b1;
						issue_q   <= (rd_addr_q != LastSlot);
					end

					// Data side: the slot read in the previous cycle.
					if (rd_vld_s1) begin
						cand_q  <= cand_nx;
						bound_q <= bound_nx;
						if (!free_found_q && !e_v) begin
							free_found_q <= 1'b1;
							free_idx_q   <= rd_idx_s1;
						end
						if (finish) begin
							state_q <= S_DONE;
							if (rel_hit) begin
								res_st_q <= ST_OK;
								count_q  <= count_q - 1'b1;
							end else if (rel_miss) begin
								res_st_q <= ST_NOT_LIVE;
							end else if (scan_abort || !free_now) begin
								res_st_q <= ST_FULL;
							end else begin
								res_st_q <= ST_OK;
								res_id_q <= IdFieldW'(cand_nx);
								last_q   <= cand_nx;
								safe_q   <= bound_nx;
								count_q  <= count_q + 1'b1;
							end
						end else if (restart) begin
							passes_q <= passes_q + 1'b1;
						end
					end
				end

				S_DONE: begin
					if (out_load) begin
						out_id_q <= res_id_q;
						out_st_q <= res_st_q;
						state_q  <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign issued_id = out_id_q;
	assign status    = out_st_q;

endmodule

/* src/uida_checker.sv */
// Port-level checker for the identifier allocator, bound to the top level.
// Depends on uida_pkg and unique_id_allocator_window_scan_assert.svh.
`include "unique_id_allocator_window_scan_assert.svh"

module uida_checker
	import uida_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input logic [IdFieldW-1:0] issued_id,
	input logic [StatusW-1:0]  status
);

	// A result carries one of the three defined status codes.
	`UIDA_ASSERT_NOW(a_status_code, out_valid, (status == ST_OK) || (status == ST_FULL) || (status == ST_NOT_LIVE), "result status code undefined")

	// A refused or failed request never hands out an identifier.
	`UIDA_ASSERT_NOW(a_no_id_on_error, out_valid && (status != ST_OK), issued_id == '0, "identifier issued with an error status")

	// The block works on one item at a time.
	`UIDA_ASSERT_NEXT(a_one_in_work, in_valid && !in_stall, in_stall, "second item taken while one is in work")

	// A stalled result stays put.
	`UIDA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(issued_id) && $stable(status), "stalled result changed")

endmodule

bind unique_id_allocator_window_scan uida_checker u_uida_checker (.*);

/* tb/sv/unique_id_allocator_window_scan_checker.sv */
// Checker for the identifier allocator: follows both item channels and keeps a
// shadow of the live table to work out each result item. Depends on uida_pkg.
`timescale 1ns / 1ps

module unique_id_allocator_window_scan_checker
	import uida_pkg::*;
#(
	parameter int unsigned ENTRIES  = EntriesDef,
	parameter int unsigned ID_LIMIT = IdLimitDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  logic                opcode,
	input  logic [IdFieldW-1:0] release_id,
	input  logic                out_valid,
	input  logic                out_stall,
	input  logic [IdFieldW-1:0] issued_id,
	input  logic [StatusW-1:0]  status,
	output int                  failures,
	output int                  awaiting
);

	typedef struct packed {
		logic [IdFieldW-1:0] id;
		status_t             st;
	} answer_t;

	// Shadow of the allocator state.
	logic [IdFieldW-1:0] held_id [ENTRIES];
	bit                  held_live [ENTRIES];
	int unsigned         last_id;
	int unsigned         bound;
	int unsigned         held_count;

	answer_t answers_due [$];

	// Works out the answer to one request and updates the shadow state.
	function automatic answer_t predict_answer(input opcode_t op,
		input logic [IdFieldW-1:0] rid);
		answer_t     a;
		int unsigned cand;
		int unsigned lim;
		int unsigned passes;
		bit          rescan;
		a.id = '0;
		a.st = ST_OK;
		if (op == OP_RELEASE) begin
			for (int s = 0; s < ENTRIES; s++) begin
				if (held_live[s] && held_id[s] == rid) begin
					held_live[s] = 1'b0;
					held_id[s]   = '0;
					held_count--;
					return a;
				end
			end
			a.st = ST_NOT_LIVE;
			return a;
		end
		if (held_count >= ENTRIES || held_count >= ID_LIMIT - 1) begin
			a.st = ST_FULL;
			return a;
		end
		cand   = last_id + 1;
		lim    = bound;
		rescan = 1'b0;
		if (cand >= ID_LIMIT) begin
			cand   = 1;
			rescan = 1'b1;
		end else if (cand >= lim) begin
			rescan = 1'b1;
		end
		if (rescan) begin
			lim    = ID_LIMIT;
			passes = 0;
			while (rescan) begin
				rescan = 1'b0;
				if (passes > ID_LIMIT + 1) begin
					a.st = ST_FULL;
					return a;
				end
				passes++;
				for (int s = 0; s < ENTRIES; s++) begin
					if (!held_live[s])
						continue;
					if (held_id[s] == cand) begin
						cand++;
						if (cand >= lim) begin
							if (cand >= ID_LIMIT)
								cand = 1;
							lim    = ID_LIMIT;
							rescan = 1'b1;
							break;
						end
					end else if (held_id[s] > cand && lim > held_id[s]) begin
						lim = held_id[s];
					end
				end
			end
		end
		for (int s = 0; s < ENTRIES; s++) begin
			if (!held_live[s]) begin
				held_live[s] = 1'b1;
				held_id[s]   = cand[IdFieldW-1:0];
				held_count++;
				last_id = cand;
				bound   = lim;
				a.id    = cand[IdFieldW-1:0];
				return a;
			end
		end
		a.st = ST_FULL;
		return a;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		answer_t want;
		if (!arst_n) begin
			for (int s = 0; s < ENTRIES; s++) begin
				held_live[s] = 1'b0;
				held_id[s]   = '0;
			end
			last_id    = ID_LIMIT;
			bound      = ID_LIMIT;
			held_count = 0;
			failures   = 0;
			answers_due.delete();
		end else begin
			// A result item always belongs to an earlier request, so it is
			// compared before any request taken at the same edge.
			if (out_valid && !out_stall) begin
				if (answers_due.size() == 0) begin
					$error("result item with nothing outstanding: issued_id %0d status %0d",
						issued_id, status);
					failures++;
				end else begin
					want = answers_due.pop_front();
					if (issued_id !== want.id) begin
						$error("issued_id: expected %0d, got %0d", want.id, issued_id);
						failures++;
					end
					if (status !== want.st) begin
						$error("status: expected %0d, got %0d", want.st, status);
						failures++;
					end
				end
			end
			if (in_valid && !in_stall)
				answers_due.push_back(predict_answer(opcode_t'(opcode), release_id));
		end
		awaiting = answers_due.size();
	end

endmodule

/* tb/sv/unique_id_allocator_window_scan_test.sv */
// Top of the identifier allocator testbench: clock, reset, request stimulus and
// result-side stalls. Depends on uida_pkg and the allocator checker.
`timescale 1ns / 1ps

module unique_id_allocator_window_scan_test
	import uida_pkg::*;
();

	localparam int unsigned RandomItems = 836;
	// Cycles with no item moving on either side before the run is abandoned.
	// The slowest allocate rescans the table a few dozen times, so this
	// leaves a wide margin.
	localparam int unsigned IdleLimit = 20000;

	typedef enum int unsigned {
		FLOW_FREE,
		FLOW_COIN,
		FLOW_PERIODIC,
		FLOW_CHOKED
	} flow_t;

	logic                clk        = 1'b0;
	logic                arst_n     = 1'b0;
	logic                in_valid   = 1'b0;
	logic                in_stall;
	logic                opcode     = OP_ALLOC;
	logic [IdFieldW-1:0] release_id = '0;
	logic                out_valid;
	logic                out_stall  = 1'b0;
	logic [IdFieldW-1:0] issued_id;
	logic [StatusW-1:0]  status;

	int failures;
	int awaiting;

	// Identifiers seen leaving the block; releases mostly draw from here so
	// that the table actually drains as well as fills.
	logic [IdFieldW-1:0] issued_pool [$];

	int unsigned burst_left = 0;
	int unsigned idle_cycles = 0;
	flow_t       flow_mode = FLOW_FREE;
	int unsigned flow_left = 0;

	always #1 clk = ~clk;

	unique_id_allocator_window_scan uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.opcode     (opcode),
		.release_id (release_id),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.issued_id  (issued_id),
		.status     (status)
	);

	unique_id_allocator_window_scan_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.opcode     (opcode),
		.release_id (release_id),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.issued_id  (issued_id),
		.status     (status),
		.failures   (failures),
		.awaiting   (awaiting)
	);

	// Presents one request item at a falling edge and holds it until the
	// block takes it. Items go out in bursts of random length; between
	// bursts valid drops for a gap that is usually short and now and then
	// long enough to leave the block idle.
	task automatic push_request(input opcode_t op, input logic [IdFieldW-1:0] rid);
		@(negedge clk);
		in_valid   <= 1'b1;
		opcode     <= op;
		release_id <= rid;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (burst_left == 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			if ($urandom_range(0, 3) == 0)
				repeat ($urandom_range(0, 60)) @(negedge clk);
			else
				repeat ($urandom_range(0, 4)) @(negedge clk);
			burst_left = $urandom_range(0, 12);
		end else begin
			burst_left--;
		end
	endtask

	// The result side changes its behaviour every so often: no stalls at
	// all, a coin toss each cycle, a fixed rhythm, or stalling most of the
	// time so that results pile up behind the output register.
	always @(negedge clk) begin
		if (flow_left == 0) begin
			flow_mode = flow_t'($urandom_range(0, 3));
			flow_left = $urandom_range(20, 200);
		end else begin
			flow_left--;
		end
		case (flow_mode)
			FLOW_FREE:     out_stall <= 1'b0;
			FLOW_COIN:     out_stall <= ($urandom_range(0, 1) == 1);
			FLOW_PERIODIC: out_stall <= ((flow_left % 5) < 3);
			default:       out_stall <= ($urandom_range(0, 9) != 0);
		endcase
	end

	always @(posedge clk) begin
		if (out_valid && !out_stall && issued_id != '0)
			issued_pool.push_back(issued_id);
	end

	// The watchdog counts cycles in which neither channel moves an item;
	// the table clearing after reset is well inside the limit.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= IdleLimit) begin
			$display("Some tests failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		int unsigned         phase_left;
		int unsigned         alloc_pct;
		int unsigned         pick;
		opcode_t             op;
		logic [IdFieldW-1:0] rid;

		phase_left = 0;
		alloc_pct  = 50;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;

		// Directed opening. Releases on an empty table, including the lowest
		// and highest identifier values, must all report not live.
		push_request(OP_RELEASE, 6'd0);
		push_request(OP_RELEASE, 6'h3F);
		push_request(OP_RELEASE, 6'd1);
		// The first allocate wraps from the reset value and scans the empty
		// table; the next ones lie below the safe bound and need no scan.
		// The ignored release field carries both extremes meanwhile.
		push_request(OP_ALLOC, 6'h3F);
		push_request(OP_ALLOC, 6'h00);
		push_request(OP_ALLOC, 6'h2A);
		push_request(OP_ALLOC, 6'h15);
		push_request(OP_ALLOC, 6'h3F);
		push_request(OP_ALLOC, 6'h00);
		// Release of a live identifier, then the same one again, which is
		// no longer live.
		push_request(OP_RELEASE, 6'd3);
		push_request(OP_RELEASE, 6'd3);
		push_request(OP_ALLOC, 6'h00);
		push_request(OP_RELEASE, 6'd1);
		push_request(OP_ALLOC, 6'h3F);
		push_request(OP_RELEASE, 6'd62);

		// Random part. Phases lean towards allocation, towards release or
		// neither, so the table repeatedly runs full and drains again. The
		// identifier counter wraps many times over the run, which gives the
		// window scan collisions and rescans against long-lived holders.
		for (int n = 0; n < RandomItems; n++) begin
			if (phase_left == 0) begin
				case ($urandom_range(0, 2))
					0:       alloc_pct = 85;
					1:       alloc_pct = 20;
					default: alloc_pct = 50;
				endcase
				phase_left = $urandom_range(20, 70);
			end
			phase_left--;
			rid = IdFieldW'($urandom);
			if ($urandom_range(1, 100) <= alloc_pct) begin
				op = OP_ALLOC;
			end else begin
				op = OP_RELEASE;
				// Most releases name an identifier known to be held; the
				// rest are arbitrary values and often miss.
				if (issued_pool.size() != 0 && $urandom_range(0, 99) < 85) begin
					pick = $urandom_range(0, issued_pool.size() - 1);
					rid  = issued_pool[pick];
					issued_pool.delete(pick);
				end
			end
			push_request(op, rid);
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (awaiting != 0)
			@(negedge clk);
		// Leave room for any stray result item to show up.
		repeat (4 * EntriesDef) @(negedge clk);
		if (failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
